### rtl/frma_pkg.sv
package frma_pkg;

  localparam int RAW_W     = 10;
  localparam int BTN_W     = 8;
  localparam int EP_W      = 4;
  localparam int GAIN_W    = 8;
  localparam int THR_W     = 10;
  localparam int TOTAL_W   = 32;
  localparam int OUT_W     = 8;
  localparam int NUM_CH    = 4;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE = 1'b1;

  localparam logic [GAIN_W-1:0] GAIN_RST  = 8'd2;
  localparam logic [THR_W-1:0]  NOISE_RST = 10'd1;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_POLL   = 1'b1;

  localparam logic [EP_W-1:0] REPORT_EP = 4'd1;

  localparam int SCALE_DIV  = 10;
  localparam int ROUND_BIAS = 5;
  localparam int CLAMP_MAX  = 127;
  localparam int CLAMP_MIN  = -127;

  localparam int CH_NORTH = 0;
  localparam int CH_EAST  = 1;
  localparam int CH_SOUTH = 2;
  localparam int CH_WEST  = 3;

  typedef struct packed {
    logic acc0;
    logic fin0;
    logic ld2;
    logic ld3;
    logic ld4;
    logic add;
    logic clr;
  } frma_ctl_t;

  typedef struct packed {
    logic             ld;
    logic             hit;
    logic [BTN_W-1:0] btn;
  } frma_rpt_t;

endpackage

### rtl/frma_lane.sv
module frma_lane #(
  parameter int AVG_COUNT   = 16,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  frma_pkg::frma_ctl_t                  ctl,
  input  logic [SAMPLE_BITS-1:0]               sample,
  input  logic [frma_pkg::GAIN_W-1:0]          gain,
  input  logic [frma_pkg::THR_W-1:0]           threshold,
  output logic signed [frma_pkg::TOTAL_W-1:0]  total
);
  import frma_pkg::*;

  localparam int DIV_L  = $clog2(AVG_COUNT);
  localparam int SUM_W  = SAMPLE_BITS + DIV_L;
  localparam int DIV_K  = SUM_W + DIV_L;
  localparam int DIV_MW = SUM_W + 2;
  localparam longint unsigned DIV_M_L = (64'd1 << DIV_K) / AVG_COUNT + 64'd1;
  localparam logic [DIV_MW-1:0] DIV_M = DIV_MW'(DIV_M_L);
  localparam int DPW    = SUM_W + DIV_MW;

  localparam int PW     = SAMPLE_BITS + GAIN_W;
  localparam int TEN_L  = $clog2(SCALE_DIV);
  localparam int TEN_K  = PW + TEN_L;
  localparam int TEN_MW = PW + 2;
  localparam longint unsigned TEN_M_L = (64'd1 << TEN_K) / SCALE_DIV + 64'd1;
  localparam logic [TEN_MW-1:0] TEN_M = TEN_MW'(TEN_M_L);
  localparam int TPW    = PW + TEN_MW;
  localparam int SCW    = PW - 3;

  localparam int CW     = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
  localparam int SUMT_W = TOTAL_W + 1;

  localparam logic [TOTAL_W-1:0] TOT_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
  localparam logic [TOTAL_W-1:0] TOT_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

  logic [SUM_W-1:0]       raw_sum_r;
  logic [SUM_W-1:0]       sum_r;
  logic [SUM_W-1:0]       sum_nxt;
  logic [DPW-1:0]         dprod;
  logic [SAMPLE_BITS-1:0] avg;
  logic [SAMPLE_BITS-1:0] last_avg_r;
  logic [SAMPLE_BITS-1:0] mag;
  logic [SAMPLE_BITS-1:0] mag_nxt;
  logic [SAMPLE_BITS-1:0] mag_r;
  logic [PW-1:0]          prod_nxt;
  logic [PW-1:0]          prod_r;
  logic [TPW-1:0]         tprod;
  logic [SCW-1:0]         scaled_nxt;
  logic [SCW-1:0]         scaled_r;
  logic [SUMT_W-1:0]      tsum;
  logic [TOTAL_W-1:0]     total_nxt;
  logic [TOTAL_W-1:0]     total_r;

  assign sum_nxt = raw_sum_r + SUM_W'(sample);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_sum_r <= '0;
    end else if (ctl.acc0) begin
      raw_sum_r <= ctl.fin0 ? '0 : sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.acc0 && ctl.fin0) begin
      sum_r <= sum_nxt;
    end
  end

  // floor(sum / AVG_COUNT) by reciprocal
  assign dprod = DPW'(sum_r) * DPW'(DIV_M);
  assign avg   = SAMPLE_BITS'(dprod >> DIV_K);
  assign mag   = (avg >= last_avg_r) ? (avg - last_avg_r) : (last_avg_r - avg);
  assign mag_nxt = (CW'(mag) > CW'(threshold)) ? mag : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_avg_r <= '0;
    end else if (ctl.ld2) begin
      last_avg_r <= avg;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      mag_r <= mag_nxt;
    end
  end

  assign prod_nxt = PW'(mag_r) * PW'(gain) + PW'(ROUND_BIAS);

  always_ff @(posedge clk) begin
    if (ctl.ld3) begin
      prod_r <= prod_nxt;
    end
  end

  // floor(prod / 10) by reciprocal
  assign tprod      = TPW'(prod_r) * TPW'(TEN_M);
  assign scaled_nxt = SCW'(tprod >> TEN_K);

  always_ff @(posedge clk) begin
    if (ctl.ld4) begin
      scaled_r <= scaled_nxt;
    end
  end

  assign tsum = {total_r[TOTAL_W-1], total_r} + SUMT_W'(scaled_r);

  always_comb begin
    total_nxt = tsum[TOTAL_W-1:0];
    if (tsum[SUMT_W-1:SUMT_W-2] == 2'b01) begin
      total_nxt = TOT_MAX;
    end else if (tsum[SUMT_W-1:SUMT_W-2] == 2'b10) begin
      total_nxt = TOT_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (ctl.clr) begin
      total_r <= '0;
    end else if (ctl.add) begin
      total_r <= total_nxt;
    end
  end

  assign total = total_r;

endmodule

### rtl/frma_merge.sv
module frma_merge (
  input  logic                                clk,
  input  logic                                rst_n,
  input  frma_pkg::frma_rpt_t                 rpt,
  input  logic signed [frma_pkg::TOTAL_W-1:0] tot_north,
  input  logic signed [frma_pkg::TOTAL_W-1:0] tot_east,
  input  logic signed [frma_pkg::TOTAL_W-1:0] tot_south,
  input  logic signed [frma_pkg::TOTAL_W-1:0] tot_west,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic                                out_empty_res,
  output logic [frma_pkg::BTN_W-1:0]          out_buttons_out,
  output logic signed [frma_pkg::OUT_W-1:0]   out_delta_x,
  output logic signed [frma_pkg::OUT_W-1:0]   out_delta_y
);
  import frma_pkg::*;

  localparam int DIFF_W = TOTAL_W + 1;

  function automatic logic signed [OUT_W-1:0] clamp_diff(input logic signed [DIFF_W-1:0] d);
    logic signed [OUT_W-1:0] res;
    res = OUT_W'(d);
    if (d > DIFF_W'(CLAMP_MAX)) begin
      res = OUT_W'(CLAMP_MAX);
    end else if (d < DIFF_W'(CLAMP_MIN)) begin
      res = OUT_W'(CLAMP_MIN);
    end
    return res;
  endfunction

  logic signed [DIFF_W-1:0] dx_full;
  logic signed [DIFF_W-1:0] dy_full;
  logic                     valid_r;
  logic                     empty_r;
  logic [BTN_W-1:0]         buttons_r;
  logic signed [OUT_W-1:0]  dx_r;
  logic signed [OUT_W-1:0]  dy_r;

  assign dx_full = DIFF_W'(tot_east) - DIFF_W'(tot_west);
  assign dy_full = DIFF_W'(tot_south) - DIFF_W'(tot_north);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (rpt.ld) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rpt.ld) begin
      empty_r   <= !rpt.hit;
      buttons_r <= rpt.hit ? rpt.btn : '0;
      dx_r      <= rpt.hit ? clamp_diff(dx_full) : '0;
      dy_r      <= rpt.hit ? clamp_diff(dy_full) : '0;
    end
  end

  assign out_valid       = valid_r;
  assign out_empty_res   = empty_r;
  assign out_buttons_out = buttons_r;
  assign out_delta_x     = dx_r;
  assign out_delta_y     = dy_r;

endmodule

### rtl/four_roller_motion_accumulator_core.sv
// Four-roller motion accumulator. Each item is either a sample set (four raw roller
// readings) or a report poll. Sample sets are summed per roller; every AVG_COUNT sample
// sets the averages are formed, the rectified change against the previous average is
// compared with noise_threshold, scaled by gain/10 with rounding and added into four
// saturating 32-bit totals, one lane per roller. A poll of endpoint 1 returns the buttons
// and the clamped differences east-west and south-north, then clears the totals; a poll
// of any other endpoint returns an empty report and changes nothing. Sample sets give no
// result. The block accepts one item per cycle; an item passes a four-stage lane pipeline
// (average, scale multiply, divide by ten, accumulate) and a poll's result is loaded into
// the output register as the poll leaves the last stage. Input stalls only once a finished
// report waits untaken, a further poll holds at the last stage and the stages behind it
// are full.
module four_roller_motion_accumulator_core #(
  parameter int AVG_COUNT   = 16,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_command,
  input  logic [frma_pkg::RAW_W-1:0]          in_north_sample,
  input  logic [frma_pkg::RAW_W-1:0]          in_east_sample,
  input  logic [frma_pkg::RAW_W-1:0]          in_south_sample,
  input  logic [frma_pkg::RAW_W-1:0]          in_west_sample,
  input  logic [frma_pkg::BTN_W-1:0]          in_button_bits,
  input  logic [frma_pkg::EP_W-1:0]           in_endpoint,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_empty_res,
  output logic [frma_pkg::BTN_W-1:0]          out_buttons_out,
  output logic signed [frma_pkg::OUT_W-1:0]   out_delta_x,
  output logic signed [frma_pkg::OUT_W-1:0]   out_delta_y,
  input  logic                                cfg_we,
  input  logic [frma_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [frma_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import frma_pkg::*;

  localparam int CNT_W = (AVG_COUNT > 1) ? $clog2(AVG_COUNT) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(AVG_COUNT - 1);

  typedef struct packed {
    logic             fin;
    logic             poll;
    logic             hit;
    logic [BTN_W-1:0] btn;
  } tag_t;

  logic [GAIN_W-1:0]      gain_r;
  logic [THR_W-1:0]       thr_r;
  logic [CNT_W-1:0]       count_r;
  logic [4:1]             v_r;
  tag_t                   tag_r [1:4];
  tag_t                   tag_in;
  logic [4:1]             mv;
  logic                   acc_in;
  logic                   acc_smp;
  frma_ctl_t              ctl;
  frma_rpt_t              rpt;
  logic [SAMPLE_BITS-1:0] smp [NUM_CH];
  logic signed [TOTAL_W-1:0] tot [NUM_CH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RST;
      thr_r  <= NOISE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAIN:  gain_r <= cfg_data[GAIN_W-1:0];
        CFG_NOISE: thr_r  <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign acc_in  = in_valid && in_ready;
  assign acc_smp = acc_in && (in_command == CMD_SAMPLE);

  assign tag_in.fin  = (in_command == CMD_SAMPLE) && (count_r == CNT_LAST);
  assign tag_in.poll = (in_command == CMD_POLL);
  assign tag_in.hit  = (in_endpoint == REPORT_EP);
  assign tag_in.btn  = in_button_bits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (acc_smp) begin
      count_r <= tag_in.fin ? '0 : count_r + CNT_W'(1);
    end
  end

  // hold a poll at the last stage while the report register is occupied
  always_comb begin
    mv[4] = v_r[4] && (!tag_r[4].poll || !out_valid || out_ready);
    for (int k = 3; k >= 1; k--) begin
      mv[k] = v_r[k] && (!v_r[k+1] || mv[k+1]);
    end
  end

  assign in_ready = !v_r[1] || mv[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r[1] <= acc_in ? 1'b1 : (mv[1] ? 1'b0 : v_r[1]);
      for (int k = 2; k <= 4; k++) begin
        v_r[k] <= mv[k-1] ? 1'b1 : (mv[k] ? 1'b0 : v_r[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      tag_r[1] <= tag_in;
    end
    for (int k = 2; k <= 4; k++) begin
      if (mv[k-1]) begin
        tag_r[k] <= tag_r[k-1];
      end
    end
  end

  assign ctl.acc0 = acc_smp;
  assign ctl.fin0 = tag_in.fin;
  assign ctl.ld2  = mv[1] && tag_r[1].fin;
  assign ctl.ld3  = mv[2] && tag_r[2].fin;
  assign ctl.ld4  = mv[3] && tag_r[3].fin;
  assign ctl.add  = mv[4] && tag_r[4].fin;
  assign ctl.clr  = mv[4] && tag_r[4].poll && tag_r[4].hit;

  assign rpt.ld  = mv[4] && tag_r[4].poll;
  assign rpt.hit = tag_r[4].hit;
  assign rpt.btn = tag_r[4].btn;

  assign smp[CH_NORTH] = SAMPLE_BITS'(in_north_sample);
  assign smp[CH_EAST]  = SAMPLE_BITS'(in_east_sample);
  assign smp[CH_SOUTH] = SAMPLE_BITS'(in_south_sample);
  assign smp[CH_WEST]  = SAMPLE_BITS'(in_west_sample);

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    frma_lane #(
      .AVG_COUNT   (AVG_COUNT),
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .sample    (smp[c]),
      .gain      (gain_r),
      .threshold (thr_r),
      .total     (tot[c])
    );
  end

  frma_merge u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .rpt             (rpt),
    .tot_north       (tot[CH_NORTH]),
    .tot_east        (tot[CH_EAST]),
    .tot_south       (tot[CH_SOUTH]),
    .tot_west        (tot[CH_WEST]),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_empty_res   (out_empty_res),
    .out_buttons_out (out_buttons_out),
    .out_delta_x     (out_delta_x),
    .out_delta_y     (out_delta_y)
  );

`ifndef SYNTH
  a_report_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    rpt.ld |=> out_valid)
    else $error("poll left the pipeline without a report");

  a_run_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_smp && count_r == CNT_LAST) |=> (count_r == '0))
    else $error("sample counter did not wrap at end of run");

  a_totals_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    !(tot[CH_NORTH][TOTAL_W-1] || tot[CH_EAST][TOTAL_W-1] ||
      tot[CH_SOUTH][TOTAL_W-1] || tot[CH_WEST][TOTAL_W-1]))
    else $error("motion total went negative");

  a_clear_totals: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(ctl.clr)) |->
      (tot[CH_NORTH] == '0 && tot[CH_EAST] == '0 &&
       tot[CH_SOUTH] == '0 && tot[CH_WEST] == '0))
    else $error("report did not clear the totals");
`endif

endmodule

### tb/frma_tb_pkg.sv
`timescale 1ns / 100ps

package frma_tb_pkg;
  import frma_pkg::*;

  localparam int AVG_LEN = 16;
  localparam int SMP_BITS = 10;
  localparam longint TOTAL_HI = 64'sd2147483647;
  localparam longint TOTAL_LO = -64'sd2147483648;

  typedef struct packed {
    logic                           command;
    logic [NUM_CH-1:0][RAW_W-1:0]   roll;
    logic [BTN_W-1:0]               buttons;
    logic [EP_W-1:0]                ep;
  } roller_item_t;

  typedef struct packed {
    logic                    empty;
    logic [BTN_W-1:0]        buttons;
    logic signed [OUT_W-1:0] dx;
    logic signed [OUT_W-1:0] dy;
  } motion_report_t;

  class roller_report_model;
    int             gain_val;
    int             noise_val;
    int             last_avg [NUM_CH];
    longint         total [NUM_CH];
    int             raw_acc [NUM_CH];
    int             samples_in_run;
    motion_report_t pending_reports [$];
    int             mismatch_count;

    function new();
      gain_val = GAIN_RST;
      noise_val = NOISE_RST;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        last_avg[ch] = 0;
        total[ch] = 0;
        raw_acc[ch] = 0;
      end
      samples_in_run = 0;
      mismatch_count = 0;
    endfunction

    function void set_regs(int g, int n);
      gain_val = g;
      noise_val = n;
    endfunction

    function void take_item(roller_item_t it);
      int             avg;
      int             mag;
      longint         scaled;
      longint         dx;
      longint         dy;
      motion_report_t r;
      if (it.command == CMD_SAMPLE) begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
          raw_acc[ch] += int'(it.roll[ch]);
        end
        samples_in_run++;
        if (samples_in_run >= AVG_LEN) begin
          for (int ch = 0; ch < NUM_CH; ch++) begin
            avg = raw_acc[ch] / AVG_LEN;
            mag = (avg >= last_avg[ch]) ? avg - last_avg[ch] : last_avg[ch] - avg;
            last_avg[ch] = avg;
            raw_acc[ch] = 0;
            if (mag > noise_val) begin
              scaled = (longint'(mag) * longint'(gain_val) + ROUND_BIAS) / SCALE_DIV;
              total[ch] = total[ch] + scaled;
              if (total[ch] > TOTAL_HI) total[ch] = TOTAL_HI;
              if (total[ch] < TOTAL_LO) total[ch] = TOTAL_LO;
            end
          end
          samples_in_run = 0;
        end
      end else if (it.ep == REPORT_EP) begin
        dx = total[CH_EAST] - total[CH_WEST];
        dy = total[CH_SOUTH] - total[CH_NORTH];
        if (dx > CLAMP_MAX) dx = CLAMP_MAX;
        if (dx < CLAMP_MIN) dx = CLAMP_MIN;
        if (dy > CLAMP_MAX) dy = CLAMP_MAX;
        if (dy < CLAMP_MIN) dy = CLAMP_MIN;
        for (int ch = 0; ch < NUM_CH; ch++) total[ch] = 0;
        r.empty = 1'b0;
        r.buttons = it.buttons;
        r.dx = dx[OUT_W-1:0];
        r.dy = dy[OUT_W-1:0];
        pending_reports.push_back(r);
      end else begin
        r = '0;
        r.empty = 1'b1;
        pending_reports.push_back(r);
      end
    endfunction

    task flag_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $time);
      mismatch_count++;
    endtask

    task match_report(motion_report_t got);
      motion_report_t want;
      if (pending_reports.size() == 0) begin
        flag_mismatch("unexpected report", 1, 0);
      end else begin
        want = pending_reports.pop_front();
        if (got.empty !== want.empty)
          flag_mismatch("empty_res", int'(got.empty), int'(want.empty));
        if (got.buttons !== want.buttons)
          flag_mismatch("buttons_out", int'(got.buttons), int'(want.buttons));
        if (got.dx !== want.dx)
          flag_mismatch("delta_x", int'(got.dx), int'(want.dx));
        if (got.dy !== want.dy)
          flag_mismatch("delta_y", int'(got.dy), int'(want.dy));
      end
    endtask
  endclass

endpackage

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import frma_pkg::*;
  import frma_tb_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_OFF = 300;
  localparam int SETTLE = 12;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      in_command = CMD_SAMPLE;
  logic [RAW_W-1:0]          in_north_sample = '0;
  logic [RAW_W-1:0]          in_east_sample = '0;
  logic [RAW_W-1:0]          in_south_sample = '0;
  logic [RAW_W-1:0]          in_west_sample = '0;
  logic [BTN_W-1:0]          in_button_bits = '0;
  logic [EP_W-1:0]           in_endpoint = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      out_empty_res;
  logic [BTN_W-1:0]          out_buttons_out;
  logic signed [OUT_W-1:0]   out_delta_x;
  logic signed [OUT_W-1:0]   out_delta_y;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = CFG_GAIN;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  roller_report_model board = new();

  bit calm = 1'b0;
  bit stall_req = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;
  int run_pos = 0;
  int run_mode = 0;
  int roll_level [NUM_CH] = '{0, 0, 0, 0};

  four_roller_motion_accumulator_core #(
    .AVG_COUNT  (AVG_LEN),
    .SAMPLE_BITS(SMP_BITS)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_north_sample(in_north_sample),
    .in_east_sample (in_east_sample),
    .in_south_sample(in_south_sample),
    .in_west_sample (in_west_sample),
    .in_button_bits (in_button_bits),
    .in_endpoint    (in_endpoint),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_empty_res  (out_empty_res),
    .out_buttons_out(out_buttons_out),
    .out_delta_x    (out_delta_x),
    .out_delta_y    (out_delta_y),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        board.match_report(motion_report_t'{out_empty_res, out_buttons_out,
                                            out_delta_x, out_delta_y});
      end
      if (stall_req) begin
        stall_req = 1'b0;
        hold_left = HOLD_OFF;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 20);
      end
    end
  end

  task automatic send_item(roller_item_t it);
    int gap;
    if (!calm && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      gap = 1;
      while ($urandom_range(0, 99) < 20) gap++;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= it.command;
    in_north_sample <= it.roll[CH_NORTH];
    in_east_sample <= it.roll[CH_EAST];
    in_south_sample <= it.roll[CH_SOUTH];
    in_west_sample <= it.roll[CH_WEST];
    in_button_bits <= it.buttons;
    in_endpoint <= it.ep;
    do @(posedge clk); while (!in_ready);
    board.take_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_regs(int g, int n);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= CFG_GAIN;
    cfg_data <= CFG_DATA_W'(g);
    @(posedge clk);
    cfg_index <= CFG_NOISE;
    cfg_data <= CFG_DATA_W'(n);
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_regs(g, n);
  endtask

  function automatic roller_item_t make_item(int unsigned raw [NUM_CH], bit cmd,
                                             int btn, int ep);
    roller_item_t it;
    it.command = cmd;
    for (int ch = 0; ch < NUM_CH; ch++) it.roll[ch] = RAW_W'(raw[ch]);
    it.buttons = BTN_W'(btn);
    it.ep = EP_W'(ep);
    return it;
  endfunction

  function automatic roller_item_t random_item(bit poll_heavy);
    roller_item_t it;
    int v;
    it.buttons = BTN_W'($urandom);
    it.ep = EP_W'($urandom);
    for (int ch = 0; ch < NUM_CH; ch++) it.roll[ch] = RAW_W'($urandom);
    if (poll_heavy) it.command = ($urandom_range(0, 3) != 0) ? CMD_POLL : CMD_SAMPLE;
    else it.command = ($urandom_range(0, 5) == 0) ? CMD_POLL : CMD_SAMPLE;
    if (it.command == CMD_POLL) begin
      if ($urandom_range(0, 3) != 0) it.ep = REPORT_EP;
      return it;
    end
    if (run_pos == 0) begin
      run_mode = $urandom_range(0, 3);
      for (int ch = 0; ch < NUM_CH; ch++) begin
        case (run_mode)
          0: begin
            if ($urandom_range(0, 3) == 0) roll_level[ch] = $urandom_range(0, 1) * 1023;
            else roll_level[ch] = $urandom_range(0, 1023);
          end
          1: begin
            roll_level[ch] = roll_level[ch] + int'($urandom_range(0, 40)) - 20;
            if (roll_level[ch] < 0) roll_level[ch] = 0;
            if (roll_level[ch] > 1023) roll_level[ch] = 1023;
          end
          default: begin
          end
        endcase
      end
    end
    if (run_mode != 3) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        v = roll_level[ch] + int'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        it.roll[ch] = RAW_W'(v);
      end
    end
    run_pos = (run_pos + 1) % AVG_LEN;
    return it;
  endfunction

  task automatic random_phase(int count, bit squeeze);
    if (squeeze) begin
      stall_req = 1'b1;
      repeat (40) send_item(random_item(1'b1));
    end
    repeat (count) send_item(random_item(1'b0));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(make_item('{0, 0, 0, 0}, CMD_POLL, 8'h00, REPORT_EP));
    send_item(make_item('{1023, 1023, 1023, 1023}, CMD_POLL, 8'hFF, 0));
    send_item(make_item('{0, 1023, 0, 1023}, CMD_POLL, 8'hA5, 15));
    repeat (AVG_LEN) send_item(make_item('{0, 1023, 1023, 0}, CMD_SAMPLE, 8'hFF, 15));
    send_item(make_item('{1023, 0, 0, 1023}, CMD_POLL, 8'hFF, REPORT_EP));
    send_item(make_item('{0, 0, 0, 0}, CMD_POLL, 8'h5A, REPORT_EP));
    send_item(make_item('{0, 0, 0, 0}, CMD_POLL, 8'h00, 2));

    load_regs(0, 0);
    random_phase(250, 1'b0);
    load_regs(255, 0);
    random_phase(250, 1'b1);
    load_regs(1, 1023);
    random_phase(250, 1'b0);
    load_regs(255, 1023);
    calm = 1'b1;
    random_phase(250, 1'b0);
    calm = 1'b0;
    load_regs($urandom_range(1, 255), $urandom_range(0, 8));
    random_phase(250, 1'b0);
    load_regs($urandom_range(1, 255), $urandom_range(0, 1023));
    random_phase(250, 1'b0);
    load_regs(1, 0);
    random_phase(250, 1'b0);

    drain();
    if (board.pending_reports.size() != 0) begin
      board.flag_mismatch("reports never seen", 0, board.pending_reports.size());
    end
    if (board.mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
